// ===== rtl/core/bea_pkg.sv =====
`default_nettype none

package bea_pkg;

	// Map geometry
	localparam int MAX_ENTRIES   = 256;
	localparam int BITS_PER_WORD = 8;
	localparam int TOP_BIT       = 7;
	localparam int BIT_AW        = $clog2(BITS_PER_WORD);
	localparam int MAP_WORDS     = (MAX_ENTRIES + BITS_PER_WORD - 1) / BITS_PER_WORD;
	localparam int WORD_AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int POS_W         = WORD_AW + BIT_AW;

	// Field widths
	localparam int KIND_W   = 1;
	localparam int INDEX_W  = 8;
	localparam int STATUS_W = 2;
	localparam int FREE_W   = 9;
	localparam int CFG_W    = 9;
	localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
	localparam int EXT_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [CFG_W-1:0] ENTRY_COUNT_RST = CFG_W'(256);

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 1'b0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK          = 2'd0,
		STS_FULL        = 2'd1,
		STS_BAD_RELEASE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REL,
		ST_DONE
	} state_t;

	typedef struct packed {
		status_t              status;
		logic [INDEX_W-1:0]   granted_index;
		logic [FREE_W-1:0]    free_count;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bea_if.sv =====
`default_nettype none

interface bea_req_if;
	logic                             valid;
	logic                             ready;
	logic [bea_pkg::KIND_W-1:0]       kind;
	logic [bea_pkg::INDEX_W-1:0]      entry_index;

	modport source (output valid, output kind, output entry_index, input ready);
	modport sink   (input valid, input kind, input entry_index, output ready);
endinterface

interface bea_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [bea_pkg::STATUS_W-1:0]     status;
	logic [bea_pkg::INDEX_W-1:0]      granted_index;
	logic [bea_pkg::FREE_W-1:0]       free_count;

	modport source (output valid, output status, output granted_index, output free_count,
		input ready);
	modport sink   (input valid, input status, input granted_index, input free_count,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bea_ram.sv =====
`default_nettype none

module bea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bea_ctrl.sv =====
`default_nettype none

module bea_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	bea_req_if.sink                         req,
	input  wire logic [bea_pkg::CFG_W-1:0]  entry_count,
	output      logic                       res_valid,
	input  wire logic                       res_ready,
	output      bea_pkg::result_t           res
);

	localparam int WORD_AW = bea_pkg::WORD_AW;
	localparam int EXT_W   = bea_pkg::EXT_W;
	localparam int CNT_W   = bea_pkg::CNT_W;
	localparam int BIT_AW  = bea_pkg::BIT_AW;
	localparam int BPW     = bea_pkg::BITS_PER_WORD;

	bea_pkg::state_t                 state_q, state_d;
	logic [WORD_AW-1:0]              chk_s1, chk_d;
	logic [bea_pkg::INDEX_W-1:0]     idx_q, idx_d;
	logic [CNT_W-1:0]                used_q, used_d;
	bea_pkg::status_t                status_q, status_d;
	logic [bea_pkg::INDEX_W-1:0]     granted_q, granted_d;
	logic [bea_pkg::MAP_WORDS-1:0]   valid_q;
	logic                            set_valid;

	logic                            ram_we, ram_re;
	logic [WORD_AW-1:0]              ram_waddr, ram_raddr;
	logic [BPW-1:0]                  ram_wdata, ram_rdata;

	logic [EXT_W-1:0]                n_ext;
	logic [EXT_W-1:0]                used_ext;
	logic [WORD_AW-1:0]              rel_word;
	logic [BIT_AW-1:0]               rel_bit;
	logic [WORD_AW-1:0]              rd_word;
	logic [BPW-1:0]                  word_data;
	logic                            hit;
	logic [BIT_AW-1:0]               hit_pos;
	logic                            last_word;

	bea_ram #(
		.WIDTH (BPW),
		.DEPTH (bea_pkg::MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Active entry count, limited to the map depth
	always_comb begin
		if (EXT_W'(entry_count) > EXT_W'(bea_pkg::MAX_ENTRIES)) begin
			n_ext = EXT_W'(bea_pkg::MAX_ENTRIES);
		end else begin
			n_ext = EXT_W'(entry_count);
		end
	end

	assign used_ext = EXT_W'(used_q);
	assign rel_word = WORD_AW'(idx_q >> BIT_AW);
	assign rel_bit  = BIT_AW'(bea_pkg::TOP_BIT) - idx_q[BIT_AW-1:0];
	assign rd_word  = (state_q == bea_pkg::ST_REL) ? rel_word : chk_s1;

	// Words never written since reset read as all free
	assign word_data = valid_q[rd_word] ? ram_rdata : '0;

	// Lowest free entry of the word under check that lies below the active count
	always_comb begin
		logic [EXT_W-1:0] pos;
		hit     = 1'b0;
		hit_pos = '0;
		for (int j = 0; j < BPW; j++) begin
			pos = EXT_W'({chk_s1, BIT_AW'(j)});
			if (!hit && !word_data[bea_pkg::TOP_BIT - j] && (pos < n_ext)) begin
				hit     = 1'b1;
				hit_pos = BIT_AW'(j);
			end
		end
	end

	// Word under check holds the last active entry
	assign last_word = (EXT_W'({chk_s1, {BIT_AW{1'b1}}}) + EXT_W'(1)) >= n_ext;

	// Next state and memory access
	always_comb begin
		state_d   = state_q;
		chk_d     = chk_s1;
		idx_d     = idx_q;
		used_d    = used_q;
		status_d  = status_q;
		granted_d = granted_q;
		set_valid = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = word_data;
		req.ready = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			bea_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					idx_d     = req.entry_index;
					granted_d = '0;
					if (req.kind == bea_pkg::KIND_ALLOC) begin
						if (n_ext == '0) begin
							status_d = bea_pkg::STS_FULL;
							state_d  = bea_pkg::ST_DONE;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = '0;
							chk_d     = '0;
							state_d   = bea_pkg::ST_SCAN;
						end
					end else begin
						ram_re    = 1'b1;
						ram_raddr = WORD_AW'(req.entry_index >> BIT_AW);
						state_d   = bea_pkg::ST_REL;
					end
				end
			end
			bea_pkg::ST_SCAN: begin
				if (hit) begin
					ram_we    = 1'b1;
					ram_waddr = chk_s1;
					ram_wdata = word_data;
					ram_wdata[BIT_AW'(bea_pkg::TOP_BIT) - hit_pos] = 1'b1;
					set_valid = 1'b1;
					used_d    = used_q + CNT_W'(1);
					status_d  = bea_pkg::STS_OK;
					granted_d = bea_pkg::INDEX_W'({chk_s1, hit_pos});
					state_d   = bea_pkg::ST_DONE;
				end else if (last_word) begin
					status_d = bea_pkg::STS_FULL;
					state_d  = bea_pkg::ST_DONE;
				end else begin
					// fetch the next word while this one is checked
					ram_re    = 1'b1;
					ram_raddr = chk_s1 + WORD_AW'(1);
					chk_d     = chk_s1 + WORD_AW'(1);
				end
			end
			bea_pkg::ST_REL: begin
				if ((EXT_W'(idx_q) < n_ext) && word_data[rel_bit]) begin
					ram_we    = 1'b1;
					ram_waddr = rel_word;
					ram_wdata = word_data;
					ram_wdata[rel_bit] = 1'b0;
					set_valid = 1'b1;
					if (used_q != '0) begin
						used_d = used_q - CNT_W'(1);
					end
					status_d = bea_pkg::STS_OK;
				end else begin
					status_d = bea_pkg::STS_BAD_RELEASE;
				end
				state_d = bea_pkg::ST_DONE;
			end
			bea_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = bea_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bea_pkg::ST_IDLE;
			end
		endcase
	end

	// Result, free count floored at zero
	always_comb begin
		res.status        = status_q;
		res.granted_index = granted_q;
		if (used_ext >= n_ext) begin
			res.free_count = '0;
		end else begin
			res.free_count = bea_pkg::FREE_W'(n_ext - used_ext);
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bea_pkg::ST_IDLE;
			used_q  <= '0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (set_valid) begin
				valid_q[ram_waddr] <= 1'b1;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		chk_s1    <= chk_d;
		idx_q     <= idx_d;
		status_q  <= status_d;
		granted_q <= granted_d;
	end

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_entry_allocator.sv =====
// Channel  Dir  Fields                                    Transfer
// req      in   kind, entry_index                         req.valid & req.ready
// rsp      out  status, granted_index, free_count         rsp.valid & rsp.ready
// cfg      in   cfg_wdata (entry_count)                   cfg_we
//
// Allocate scans the use map one 8-entry memory word per cycle. Release reads the word,
// modifies and writes it, then gives the result. The map memory read latency sets the
// per-word pace.
// Reset clears the map through per-word valid flops; no clearing pass is needed.
// A result waits in the output register while the next request is taken; a request
// finishing while that register is still full stalls until it is taken.

`default_nettype none

module bitmap_entry_allocator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	bea_req_if.sink                         req,
	bea_rsp_if.source                       rsp,
	input  wire logic                       cfg_we,
	input  wire logic [bea_pkg::CFG_W-1:0]  cfg_wdata
);

	logic [bea_pkg::CFG_W-1:0] entry_count_q;
	logic                      res_valid;
	logic                      res_ready;
	bea_pkg::result_t          res;
	logic                      out_valid_q;
	bea_pkg::result_t          out_q;

	// Hold the entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= bea_pkg::ENTRY_COUNT_RST;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	bea_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.entry_count (entry_count_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Output register: load when empty or being drained
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.granted_index = out_q.granted_index;
	assign rsp.free_count    = out_q.free_count;

endmodule

`default_nettype wire
